[sv/assert_macros.svh]
// Assertion shorthands used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define SFP_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("sfp assertion failed");

// Next-cycle implication, off while reset is high.
`define SFP_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("sfp assertion failed");

// Next-cycle implication, checked through reset as well.
`define SFP_ASSERT_NXT_ALL(lbl, ck, ante, cons) \
  lbl: assert property (@(posedge ck) (ante) |=> (cons)) \
    else $error("sfp assertion failed");

`endif

[sv/sfp_pkg.sv]
`timescale 1ns / 1ps

package sfp_pkg;

  localparam int MAX_ARGS_DEF    = 16;
  localparam int MAX_ARG_LEN_DEF = 256;
  localparam int LEN_SLACK       = 64;
  localparam int TAG_LEN         = 4;

  localparam int OQ_DEPTH = 4;
  localparam int OQ_PW    = 2;
  localparam int OQ_CW    = 3;
  localparam int PUSH_MAX = 3;

  localparam logic [1:0] KIND_BYTE   = 2'd0;
  localparam logic [1:0] KIND_END    = 2'd1;
  localparam logic [1:0] KIND_FINISH = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_TAG  = 3'd1;
  localparam logic [2:0] ST_MISSING  = 3'd2;
  localparam logic [2:0] ST_TOO_MANY = 3'd3;
  localparam logic [2:0] ST_TOO_LONG = 3'd4;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SEMI  = 8'h3B;

  localparam logic [7:0] TAG_TEXT [TAG_LEN] = '{8'h47, 8'h74, 8'h67, 8'h73};

  typedef struct packed {
    logic [1:0]         kind;
    logic [3:0]         arg_index;
    logic [7:0]         arg_byte;
    logic [7:0]         arg_length;
    logic signed [31:0] stream_number;
    logic signed [31:0] frame_number;
    logic signed [31:0] command_code;
    logic [4:0]         arg_count;
    logic [2:0]         status;
    logic               last_result;
  } rec_t;

  typedef struct packed {
    logic [2:0] vld;
    rec_t       rec_a;
    rec_t       rec_b;
    rec_t       rec_c;
  } push_t;

endpackage

[sv/sfp_in_if.sv]
`timescale 1ns / 1ps

interface sfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;

  modport source (output valid, output in_byte, output last_byte, input ready);
  modport sink (input valid, input in_byte, input last_byte, output ready);
endinterface

[sv/sfp_out_if.sv]
`timescale 1ns / 1ps

interface sfp_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [3:0]         arg_index;
  logic [7:0]         arg_byte;
  logic [7:0]         arg_length;
  logic signed [31:0] stream_number;
  logic signed [31:0] frame_number;
  logic signed [31:0] command_code;
  logic [4:0]         arg_count;
  logic [2:0]         status;
  logic               last_result;

  modport source (
    output valid, output kind, output arg_index, output arg_byte, output arg_length,
    output stream_number, output frame_number, output command_code,
    output arg_count, output status, output last_result, input ready
  );
  modport sink (
    input valid, input kind, input arg_index, input arg_byte, input arg_length,
    input stream_number, input frame_number, input command_code,
    input arg_count, input status, input last_result, output ready
  );
endinterface

[sv/sfp_core.sv]
`timescale 1ns / 1ps

module sfp_core #(
  parameter int MAX_ARGS    = sfp_pkg::MAX_ARGS_DEF,
  parameter int MAX_ARG_LEN = sfp_pkg::MAX_ARG_LEN_DEF
) (
  input  logic          clk,
  input  logic          rst,
  sfp_in_if.sink        rx,
  input  logic          room,
  output sfp_pkg::push_t push
);

  localparam int LEN_LIMIT = MAX_ARGS * MAX_ARG_LEN + sfp_pkg::LEN_SLACK;
  localparam int BW = $clog2(LEN_LIMIT + 1);
  localparam int AW = $clog2(MAX_ARGS + 1);
  localparam int LW = $clog2(MAX_ARG_LEN);

  localparam logic [2:0] PH_TAG    = 3'd0;
  localparam logic [2:0] PH_STREAM = 3'd1;
  localparam logic [2:0] PH_FRAME  = 3'd2;
  localparam logic [2:0] PH_CMD    = 3'd3;
  localparam logic [2:0] PH_ARGS   = 3'd4;
  localparam logic [2:0] PH_DONE   = 3'd5;

  localparam logic [1:0] NS_SKIP   = 2'd0;
  localparam logic [1:0] NS_DIGITS = 2'd1;
  localparam logic [1:0] NS_STOP   = 2'd2;

  logic       in_vld;
  logic [7:0] in_b;
  logic       in_last;
  logic       fire;

  logic [2:0]        field_phase, field_phase_next;
  logic [2:0]        tag_progress, tag_progress_next;
  logic              tag_ok, tag_ok_next;
  logic [1:0]        num_sub, num_sub_next;
  logic              num_neg, num_neg_next;
  logic [31:0]       num_acc, num_acc_next;
  logic [31:0]       stream_reg, stream_reg_next;
  logic [31:0]       frame_reg, frame_reg_next;
  logic [31:0]       command_reg, command_reg_next;
  logic [AW-1:0]     args_seen, args_seen_next;
  logic [LW-1:0]     cur_len, cur_len_next;
  logic [BW-1:0]     bytes_seen, bytes_seen_next;
  logic [2:0]        error_code, error_code_next;
  logic              terminated, terminated_next;

  logic              over;
  logic              digit;
  logic              ws;
  logic              sign;
  logic [1:0]        sub_step;
  logic [31:0]       nv;
  logic [31:0]       nv_fin;
  logic [31:0]       cmd_fin;
  logic [AW-1:0]     cnt_fin;
  logic [2:0]        st;
  logic              va, vb, vc;
  sfp_pkg::rec_t     ra, rb, rc;

  assign rx.ready = !in_vld || room;
  assign fire     = in_vld && room;

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      in_b    <= rx.in_byte;
      in_last <= rx.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld       <= 1'b0;
      field_phase  <= PH_TAG;
      tag_progress <= '0;
      tag_ok       <= 1'b1;
      num_sub      <= NS_SKIP;
      num_neg      <= 1'b0;
      num_acc      <= '0;
      stream_reg   <= '0;
      frame_reg    <= '0;
      command_reg  <= '0;
      args_seen    <= '0;
      cur_len      <= '0;
      bytes_seen   <= '0;
      error_code   <= sfp_pkg::ST_OK;
      terminated   <= 1'b0;
    end else begin
      if (rx.ready) begin
        in_vld <= rx.valid;
      end
      if (fire) begin
        field_phase  <= field_phase_next;
        tag_progress <= tag_progress_next;
        tag_ok       <= tag_ok_next;
        num_sub      <= num_sub_next;
        num_neg      <= num_neg_next;
        num_acc      <= num_acc_next;
        stream_reg   <= stream_reg_next;
        frame_reg    <= frame_reg_next;
        command_reg  <= command_reg_next;
        args_seen    <= args_seen_next;
        cur_len      <= cur_len_next;
        bytes_seen   <= bytes_seen_next;
        error_code   <= error_code_next;
        terminated   <= terminated_next;
      end
    end
  end

  assign digit = (in_b >= sfp_pkg::CH_ZERO) && (in_b <= sfp_pkg::CH_NINE);
  assign ws    = in_b inside {sfp_pkg::CH_SPACE, [sfp_pkg::CH_TAB:sfp_pkg::CH_CR]};
  assign sign  = (in_b == sfp_pkg::CH_PLUS) || (in_b == sfp_pkg::CH_MINUS);
  assign nv    = num_neg ? (32'd0 - num_acc) : num_acc;

  always_comb begin
    field_phase_next  = field_phase;
    tag_progress_next = tag_progress;
    tag_ok_next       = tag_ok;
    num_sub_next      = num_sub;
    num_neg_next      = num_neg;
    num_acc_next      = num_acc;
    stream_reg_next   = stream_reg;
    frame_reg_next    = frame_reg;
    command_reg_next  = command_reg;
    args_seen_next    = args_seen;
    cur_len_next      = cur_len;
    error_code_next   = error_code;
    terminated_next   = terminated;
    sub_step          = num_sub;
    nv_fin            = '0;
    cmd_fin           = '0;
    cnt_fin           = '0;
    st                = sfp_pkg::ST_OK;
    va                = 1'b0;
    vb                = 1'b0;
    vc                = 1'b0;
    ra                = '0;
    rb                = '0;
    rc                = '0;

    bytes_seen_next = bytes_seen;
    if (bytes_seen < BW'(LEN_LIMIT)) begin
      bytes_seen_next = bytes_seen + 1'b1;
    end
    over = bytes_seen_next >= BW'(LEN_LIMIT);

    if (!terminated && field_phase != PH_DONE) begin
      if (in_b == sfp_pkg::CH_NUL) begin
        terminated_next = 1'b1;
      end else if (in_b == sfp_pkg::CH_SEMI) begin
        case (field_phase)
          PH_TAG: begin
            if (tag_ok && tag_progress == 3'(sfp_pkg::TAG_LEN)) begin
              field_phase_next = PH_STREAM;
            end else begin
              error_code_next  = sfp_pkg::ST_BAD_TAG;
              field_phase_next = PH_DONE;
            end
          end
          PH_STREAM: begin
            stream_reg_next  = nv;
            num_sub_next     = NS_SKIP;
            num_neg_next     = 1'b0;
            num_acc_next     = '0;
            field_phase_next = PH_FRAME;
          end
          PH_FRAME: begin
            frame_reg_next   = nv;
            num_sub_next     = NS_SKIP;
            num_neg_next     = 1'b0;
            num_acc_next     = '0;
            field_phase_next = PH_CMD;
          end
          PH_CMD: begin
            command_reg_next = nv;
            num_sub_next     = NS_SKIP;
            num_neg_next     = 1'b0;
            num_acc_next     = '0;
            field_phase_next = PH_ARGS;
            args_seen_next   = AW'(1);
            cur_len_next     = '0;
          end
          default: begin
            if (!over) begin
              va            = 1'b1;
              ra.kind       = sfp_pkg::KIND_END;
              ra.arg_index  = 4'(args_seen - 1'b1);
              ra.arg_length = 8'(cur_len);
            end
            if (args_seen >= AW'(MAX_ARGS)) begin
              error_code_next  = sfp_pkg::ST_TOO_MANY;
              field_phase_next = PH_DONE;
            end else begin
              args_seen_next = args_seen + 1'b1;
              cur_len_next   = '0;
            end
          end
        endcase
      end else if (field_phase == PH_TAG) begin
        if (tag_ok && tag_progress < 3'(sfp_pkg::TAG_LEN)
            && in_b == sfp_pkg::TAG_TEXT[tag_progress[1:0]]) begin
          tag_progress_next = tag_progress + 1'b1;
        end else begin
          tag_ok_next = 1'b0;
        end
      end else if (field_phase == PH_ARGS) begin
        if (cur_len < LW'(MAX_ARG_LEN - 1)) begin
          if (!over) begin
            va          = 1'b1;
            ra.kind     = sfp_pkg::KIND_BYTE;
            ra.arg_index = 4'(args_seen - 1'b1);
            ra.arg_byte = in_b;
          end
          cur_len_next = cur_len + 1'b1;
        end
      end else begin
        if (num_sub == NS_SKIP && !ws) begin
          if (sign) begin
            num_neg_next = (in_b == sfp_pkg::CH_MINUS);
          end
          sub_step = (sign || digit) ? NS_DIGITS : NS_STOP;
        end
        if (num_sub == NS_DIGITS || (num_sub == NS_SKIP && !ws && !sign)) begin
          if (sub_step == NS_DIGITS && digit) begin
            num_acc_next = (num_acc << 3) + (num_acc << 1) + 32'(in_b - sfp_pkg::CH_ZERO);
          end else begin
            sub_step = NS_STOP;
          end
        end
        num_sub_next = sub_step;
      end
    end

    nv_fin = num_neg_next ? (32'd0 - num_acc_next) : num_acc_next;

    if (in_last) begin
      cmd_fin = command_reg_next;
      cnt_fin = args_seen_next;
      if (over) begin
        st = sfp_pkg::ST_TOO_LONG;
      end else if (error_code_next != sfp_pkg::ST_OK) begin
        st = error_code_next;
      end else if (field_phase_next == PH_TAG) begin
        st = (tag_ok_next && tag_progress_next == 3'(sfp_pkg::TAG_LEN)) ?
             sfp_pkg::ST_MISSING : sfp_pkg::ST_BAD_TAG;
      end else if (field_phase_next == PH_STREAM || field_phase_next == PH_FRAME) begin
        st = sfp_pkg::ST_MISSING;
      end else if (field_phase_next == PH_CMD) begin
        cmd_fin = nv_fin;
        cnt_fin = '0;
      end else begin
        vb            = 1'b1;
        rb.kind       = sfp_pkg::KIND_END;
        rb.arg_index  = 4'(args_seen_next - 1'b1);
        rb.arg_length = 8'(cur_len_next);
      end

      vc             = 1'b1;
      rc.kind        = sfp_pkg::KIND_FINISH;
      rc.status      = st;
      rc.last_result = 1'b1;
      if (st == sfp_pkg::ST_OK) begin
        rc.stream_number = stream_reg_next;
        rc.frame_number  = frame_reg_next;
        rc.command_code  = cmd_fin;
        rc.arg_count     = 5'(cnt_fin);
      end

      field_phase_next  = PH_TAG;
      tag_progress_next = '0;
      tag_ok_next       = 1'b1;
      num_sub_next      = NS_SKIP;
      num_neg_next      = 1'b0;
      num_acc_next      = '0;
      stream_reg_next   = '0;
      frame_reg_next    = '0;
      command_reg_next  = '0;
      args_seen_next    = '0;
      cur_len_next      = '0;
      bytes_seen_next   = '0;
      error_code_next   = sfp_pkg::ST_OK;
      terminated_next   = 1'b0;
    end

    ra.last_result = !vc;
  end

  assign push.vld   = fire ? {vc, vb, va} : 3'b000;
  assign push.rec_a = ra;
  assign push.rec_b = rb;
  assign push.rec_c = rc;

endmodule

[sv/sfp_outq.sv]
`timescale 1ns / 1ps

module sfp_outq (
  input  logic           clk,
  input  logic           rst,
  input  sfp_pkg::push_t push,
  output logic           room,
  sfp_out_if.source      tx
);

  sfp_pkg::rec_t                 q [sfp_pkg::OQ_DEPTH];
  logic [sfp_pkg::OQ_PW-1:0]     head, tail;
  logic [sfp_pkg::OQ_PW-1:0]     pos_b, pos_c, tail_next;
  logic [sfp_pkg::OQ_CW-1:0]     count, count_next;
  logic [sfp_pkg::OQ_CW-1:0]     n_push;
  logic                          pop;
  sfp_pkg::rec_t                 hd;

  assign pos_b     = tail + sfp_pkg::OQ_PW'(push.vld[0]);
  assign pos_c     = pos_b + sfp_pkg::OQ_PW'(push.vld[1]);
  assign tail_next = pos_c + sfp_pkg::OQ_PW'(push.vld[2]);
  assign n_push    = sfp_pkg::OQ_CW'(push.vld[0]) + sfp_pkg::OQ_CW'(push.vld[1])
                   + sfp_pkg::OQ_CW'(push.vld[2]);
  assign pop        = tx.valid && tx.ready;
  assign count_next = count + n_push - sfp_pkg::OQ_CW'(pop);
  assign room       = count <= sfp_pkg::OQ_CW'(sfp_pkg::OQ_DEPTH - sfp_pkg::PUSH_MAX);

  always_ff @(posedge clk) begin
    if (push.vld[0]) begin
      q[tail] <= push.rec_a;
    end
    if (push.vld[1]) begin
      q[pos_b] <= push.rec_b;
    end
    if (push.vld[2]) begin
      q[pos_c] <= push.rec_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      tail  <= tail_next;
      count <= count_next;
      if (pop) begin
        head <= head + 1'b1;
      end
    end
  end

  assign hd               = q[head];
  assign tx.valid         = count != '0;
  assign tx.kind          = hd.kind;
  assign tx.arg_index     = hd.arg_index;
  assign tx.arg_byte      = hd.arg_byte;
  assign tx.arg_length    = hd.arg_length;
  assign tx.stream_number = hd.stream_number;
  assign tx.frame_number  = hd.frame_number;
  assign tx.command_code  = hd.command_code;
  assign tx.arg_count     = hd.arg_count;
  assign tx.status        = hd.status;
  assign tx.last_result   = hd.last_result;

endmodule

[sv/semicolon_frame_parser.sv]
`timescale 1ns / 1ps
// Port  Dir   Beat
// ----  ----  ---------------------------------------------------------------
// rx    in    one payload byte, last_byte flags the final byte of a frame
// tx    out   one record: argument byte, argument end, or frame finish
//
// An rx beat lands in the input register and is parsed there once the queue has
// room, which writes zero to three records into a four-entry result queue; tx
// shows the record at the head of the queue.
// rx takes one byte per cycle while the queue holds at most one record; a byte
// that makes two or three records holds rx until tx drains the queue.
// rst clears the parser to the start of a frame and empties the queue.
// A stall on tx never drops or repeats records; rx backs up instead.

module semicolon_frame_parser #(
  parameter int MAX_ARGS    = sfp_pkg::MAX_ARGS_DEF,
  parameter int MAX_ARG_LEN = sfp_pkg::MAX_ARG_LEN_DEF
) (
  input logic       clk,
  input logic       rst,
  sfp_in_if.sink    rx,
  sfp_out_if.source tx
);

  sfp_pkg::push_t push;
  logic           room;

  sfp_core #(
    .MAX_ARGS    (MAX_ARGS),
    .MAX_ARG_LEN (MAX_ARG_LEN)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .rx   (rx),
    .room (room),
    .push (push)
  );

  sfp_outq u_outq (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .room (room),
    .tx   (tx)
  );

endmodule

[sv/sfp_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sfp_checker (
  input logic        clk,
  input logic        rst,
  input logic        tx_valid,
  input logic        tx_ready,
  input logic [1:0]  tx_kind,
  input logic [3:0]  tx_arg_index,
  input logic [7:0]  tx_arg_byte,
  input logic [7:0]  tx_arg_length,
  input logic [31:0] tx_stream_number,
  input logic [31:0] tx_frame_number,
  input logic [31:0] tx_command_code,
  input logic [4:0]  tx_arg_count,
  input logic [2:0]  tx_status,
  input logic        tx_last_result
);

  logic         tx_fin;
  logic         tx_err;
  logic         tx_arg;
  logic         hdr_zero;
  logic         arg_clean;
  logic [126:0] tx_beat;

  assign tx_fin    = tx_valid && tx_kind == sfp_pkg::KIND_FINISH;
  assign tx_err    = tx_fin && tx_status != sfp_pkg::ST_OK;
  assign tx_arg    = tx_valid && tx_kind != sfp_pkg::KIND_FINISH;
  assign hdr_zero  = tx_stream_number == '0 && tx_frame_number == '0
                     && tx_command_code == '0 && tx_arg_count == '0;
  assign arg_clean = tx_status == sfp_pkg::ST_OK && hdr_zero;
  assign tx_beat   = {tx_kind, tx_arg_index, tx_arg_byte, tx_arg_length,
                      tx_stream_number, tx_frame_number, tx_command_code,
                      tx_arg_count, tx_status, tx_last_result};

  `SFP_ASSERT_NXT_ALL(a_reset_empty, clk, rst, !tx_valid)

  `SFP_ASSERT_NXT(a_tx_hold, clk, rst, tx_valid && !tx_ready, tx_valid && $stable(tx_beat))

  `SFP_ASSERT_IMP(a_finish_last, clk, rst, tx_fin, tx_last_result)

  `SFP_ASSERT_IMP(a_error_zero, clk, rst, tx_err, hdr_zero)

  `SFP_ASSERT_IMP(a_arg_clean, clk, rst, tx_arg, arg_clean)

endmodule

bind semicolon_frame_parser sfp_checker u_sfp_checker (
  .clk              (clk),
  .rst              (rst),
  .tx_valid         (tx.valid),
  .tx_ready         (tx.ready),
  .tx_kind          (tx.kind),
  .tx_arg_index     (tx.arg_index),
  .tx_arg_byte      (tx.arg_byte),
  .tx_arg_length    (tx.arg_length),
  .tx_stream_number (tx.stream_number),
  .tx_frame_number  (tx.frame_number),
  .tx_command_code  (tx.command_code),
  .tx_arg_count     (tx.arg_count),
  .tx_status        (tx.status),
  .tx_last_result   (tx.last_result)
);

[tb/tb_semicolon_frame_parser.sv]
`timescale 1ns / 1ps

module tb_semicolon_frame_parser;

  localparam int HALF_PERIOD = 5;
  localparam int LEN_CAP     = sfp_pkg::MAX_ARGS_DEF * sfp_pkg::MAX_ARG_LEN_DEF
                               + sfp_pkg::LEN_SLACK;
  localparam int CYCLE_LIMIT = 100_000;
  localparam int DRAIN_WAIT  = 32;
  localparam int ITEM_TARGET = 560;
  localparam int CALM_FROM   = 480;
  localparam int LONG_BYTES  = 275;
  localparam int MAX_SHOWN   = 10;
  localparam int MANY_ARGS   = sfp_pkg::MAX_ARGS_DEF + 1;

  typedef enum logic [2:0] {P_TAG, P_STREAM, P_FRAME, P_CMD, P_ARGS, P_DONE} phase_t;
  typedef enum logic [1:0] {NUM_SKIP, NUM_DIGITS, NUM_STOP} num_state_t;

  typedef struct {
    string      text;
    logic [7:0] tail;
    logic       typed;
    logic [2:0] status;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sfp_in_if  rx_if ();
  sfp_out_if tx_if ();

  semicolon_frame_parser dut (
    .clk(clk),
    .rst(rst),
    .rx (rx_if),
    .tx (tx_if)
  );

  always #HALF_PERIOD clk = ~clk;

  row_t directed_rows [4] = '{
    '{"",                    8'hFF,            1'b1, sfp_pkg::ST_BAD_TAG},
    '{"",                    sfp_pkg::CH_NUL,  1'b1, sfp_pkg::ST_BAD_TAG},
    '{"Gtg",                 "s",              1'b1, sfp_pkg::ST_MISSING},
    '{"Gtgs;-9; +8;7x;\377", sfp_pkg::CH_SEMI, 1'b0, sfp_pkg::ST_OK}
  };

  phase_t        phase;
  num_state_t    num_state;
  int            tag_pos;
  logic          tag_good;
  logic          num_neg;
  logic [31:0]   num_acc;
  logic [31:0]   stream_v;
  logic [31:0]   frame_v;
  logic [31:0]   cmd_v;
  int            args_n;
  int            cur_len;
  int            seen_cnt;
  logic [2:0]    err_code;
  logic          text_ended;

  sfp_pkg::rec_t step_out [3];
  int            step_n;
  logic          step_live;
  sfp_pkg::rec_t due_records [$];

  logic [7:0]    frame_q [$];

  int            errors;
  int            recs_checked;
  int            bytes_sent;
  int            live_bytes;
  int            frames_sent;
  int            fin_seen [8];
  int            cycles;
  int            stall_left;
  logic          calm;

  function automatic logic [31:0] number_value();
    return num_neg ? 32'd0 - num_acc : num_acc;
  endfunction

  task automatic restart_number();
    num_state = NUM_SKIP;
    num_neg   = 1'b0;
    num_acc   = '0;
  endtask

  task automatic reset_parser();
    phase      = P_TAG;
    tag_pos    = 0;
    tag_good   = 1'b1;
    restart_number();
    stream_v   = '0;
    frame_v    = '0;
    cmd_v      = '0;
    args_n     = 0;
    cur_len    = 0;
    seen_cnt   = 0;
    err_code   = sfp_pkg::ST_OK;
    text_ended = 1'b0;
  endtask

  task automatic emit(input logic [1:0] kind, input int idx, input logic [7:0] data,
                      input int len, input logic [31:0] sn, input logic [31:0] fn,
                      input logic [31:0] cn, input int cnt, input logic [2:0] st);
    sfp_pkg::rec_t r;
    r.kind          = kind;
    r.arg_index     = 4'(idx);
    r.arg_byte      = data;
    r.arg_length    = 8'(len);
    r.stream_number = sn;
    r.frame_number  = fn;
    r.command_code  = cn;
    r.arg_count     = 5'(cnt);
    r.status        = st;
    r.last_result   = 1'b0;
    step_out[step_n] = r;
    step_n++;
  endtask

  task automatic feed_number(input logic [7:0] b);
    logic dig;
    dig = (b >= sfp_pkg::CH_ZERO && b <= sfp_pkg::CH_NINE);
    if (num_state == NUM_SKIP) begin
      if (b == sfp_pkg::CH_SPACE || (b >= sfp_pkg::CH_TAB && b <= sfp_pkg::CH_CR)) return;
      if (b == sfp_pkg::CH_PLUS || b == sfp_pkg::CH_MINUS) begin
        num_neg   = (b == sfp_pkg::CH_MINUS);
        num_state = NUM_DIGITS;
        return;
      end
      num_state = dig ? NUM_DIGITS : NUM_STOP;
    end
    if (num_state == NUM_DIGITS) begin
      if (dig) num_acc = num_acc * 32'd10 + {24'd0, b - sfp_pkg::CH_ZERO};
      else num_state = NUM_STOP;
    end
  endtask

  task automatic parse_step(input logic [7:0] b, input logic lst);
    logic       over;
    logic [2:0] st;
    step_n    = 0;
    step_live = lst || (!text_ended && phase != P_DONE);
    if (seen_cnt < LEN_CAP) seen_cnt++;
    over = seen_cnt >= LEN_CAP;

    if (!text_ended && phase != P_DONE) begin
      if (b == sfp_pkg::CH_NUL) begin
        text_ended = 1'b1;
      end else if (b == sfp_pkg::CH_SEMI) begin
        case (phase)
          P_TAG: begin
            if (tag_good && tag_pos == sfp_pkg::TAG_LEN) begin
              phase = P_STREAM;
            end else begin
              err_code = sfp_pkg::ST_BAD_TAG;
              phase    = P_DONE;
            end
          end
          P_STREAM: begin
            stream_v = number_value();
            restart_number();
            phase = P_FRAME;
          end
          P_FRAME: begin
            frame_v = number_value();
            restart_number();
            phase = P_CMD;
          end
          P_CMD: begin
            cmd_v = number_value();
            restart_number();
            phase   = P_ARGS;
            args_n  = 1;
            cur_len = 0;
          end
          default: begin
            if (!over) begin
              emit(sfp_pkg::KIND_END, args_n - 1, '0, cur_len, '0, '0, '0, 0,
                   sfp_pkg::ST_OK);
            end
            if (args_n >= sfp_pkg::MAX_ARGS_DEF) begin
              err_code = sfp_pkg::ST_TOO_MANY;
              phase    = P_DONE;
            end else begin
              args_n++;
              cur_len = 0;
            end
          end
        endcase
      end else if (phase == P_TAG) begin
        if (tag_good && tag_pos < sfp_pkg::TAG_LEN && b == sfp_pkg::TAG_TEXT[tag_pos]) tag_pos++;
        else tag_good = 1'b0;
      end else if (phase == P_ARGS) begin
        if (cur_len < sfp_pkg::MAX_ARG_LEN_DEF - 1) begin
          if (!over) begin
            emit(sfp_pkg::KIND_BYTE, args_n - 1, b, 0, '0, '0, '0, 0, sfp_pkg::ST_OK);
          end
          cur_len++;
        end
      end else begin
        feed_number(b);
      end
    end

    if (lst) begin
      if (over) begin
        st = sfp_pkg::ST_TOO_LONG;
      end else if (err_code != sfp_pkg::ST_OK) begin
        st = err_code;
      end else if (phase == P_TAG) begin
        st = (tag_good && tag_pos == sfp_pkg::TAG_LEN) ? sfp_pkg::ST_MISSING
                                                       : sfp_pkg::ST_BAD_TAG;
      end else if (phase == P_STREAM || phase == P_FRAME) begin
        st = sfp_pkg::ST_MISSING;
      end else if (phase == P_CMD) begin
        cmd_v  = number_value();
        args_n = 0;
        st     = sfp_pkg::ST_OK;
      end else begin
        emit(sfp_pkg::KIND_END, args_n - 1, '0, cur_len, '0, '0, '0, 0, sfp_pkg::ST_OK);
        st = sfp_pkg::ST_OK;
      end
      if (st == sfp_pkg::ST_OK) begin
        emit(sfp_pkg::KIND_FINISH, 0, '0, 0, stream_v, frame_v, cmd_v, args_n,
             sfp_pkg::ST_OK);
      end else begin
        emit(sfp_pkg::KIND_FINISH, 0, '0, 0, '0, '0, '0, 0, st);
      end
      reset_parser();
    end

    if (step_n > 0) step_out[step_n - 1].last_result = 1'b1;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic lst, input logic typed,
                           input logic [2:0] st);
    sfp_pkg::rec_t fin;
    if (!calm && $urandom_range(0, 5) == 0) begin
      rx_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    rx_if.valid     <= 1'b1;
    rx_if.in_byte   <= b;
    rx_if.last_byte <= lst;
    @(posedge clk);
    while (!rx_if.ready) @(posedge clk);
    parse_step(b, lst);
    if (typed) begin
      fin             = '0;
      fin.kind        = sfp_pkg::KIND_FINISH;
      fin.status      = st;
      fin.last_result = 1'b1;
      step_out[step_n - 1] = fin;
    end
    for (int i = 0; i < step_n; i++) due_records.push_back(step_out[i]);
    bytes_sent++;
    if (step_live) live_bytes++;
    @(negedge clk);
  endtask

  task automatic send_frame(input logic typed, input logic [2:0] st);
    foreach (frame_q[i]) begin
      send_byte(frame_q[i], i == frame_q.size() - 1, typed && i == frame_q.size() - 1, st);
    end
    frames_sent++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) frame_q.push_back(s[i]);
  endtask

  task automatic add_number();
    int nd;
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 2)) begin
        if ($urandom_range(0, 5) == 0) frame_q.push_back(sfp_pkg::CH_SPACE);
        else frame_q.push_back(sfp_pkg::CH_TAB + 8'($urandom_range(0, 4)));
      end
    end
    case ($urandom_range(0, 3))
      0: frame_q.push_back(sfp_pkg::CH_PLUS);
      1: frame_q.push_back(sfp_pkg::CH_MINUS);
      default: ;
    endcase
    nd = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 4);
    repeat (nd) frame_q.push_back(sfp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
    if ($urandom_range(0, 4) == 0) frame_q.push_back(8'($urandom_range(1, 255)));
    if (frame_q[$] == sfp_pkg::CH_SEMI) frame_q[$] = sfp_pkg::CH_PLUS;
  endtask

  task automatic add_arg();
    logic [7:0] b;
    int         len;
    len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
    repeat (len) begin
      b = 8'($urandom_range(1, 255));
      if (b == sfp_pkg::CH_SEMI) b = 8'h80;
      frame_q.push_back(b);
    end
  endtask

  task automatic build_frame(input int force_args);
    int r;
    int nargs;
    frame_q.delete();
    r = (force_args >= 0) ? 0 : $urandom_range(0, 99);
    if (r >= 86) begin
      repeat ($urandom_range(1, 12)) frame_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    for (int i = 0; i < sfp_pkg::TAG_LEN; i++) frame_q.push_back(sfp_pkg::TAG_TEXT[i]);
    if (r >= 70 && r < 78) begin
      case ($urandom_range(0, 2))
        0: frame_q[$urandom_range(0, sfp_pkg::TAG_LEN - 1)] ^= 8'(1 << $urandom_range(0, 7));
        1: void'(frame_q.pop_back());
        default: frame_q.push_back(sfp_pkg::TAG_TEXT[sfp_pkg::TAG_LEN - 1]);
      endcase
    end
    frame_q.push_back(sfp_pkg::CH_SEMI);
    add_number();
    frame_q.push_back(sfp_pkg::CH_SEMI);
    add_number();
    frame_q.push_back(sfp_pkg::CH_SEMI);
    add_number();
    if (force_args >= 0) nargs = force_args;
    else if ($urandom_range(0, 4) == 0) nargs = $urandom_range(0, sfp_pkg::MAX_ARGS_DEF + 2);
    else nargs = $urandom_range(0, 4);
    repeat (nargs) begin
      frame_q.push_back(sfp_pkg::CH_SEMI);
      add_arg();
    end
    if (r >= 60 && r < 70) begin
      nargs = $urandom_range(1, frame_q.size());
      while (frame_q.size() > nargs) void'(frame_q.pop_back());
    end
    if (r >= 78 && r < 86) frame_q.insert($urandom_range(0, frame_q.size() - 1), sfp_pkg::CH_NUL);
  endtask

  task automatic build_long(input int total);
    frame_q.delete();
    push_text("Gtgs;12;-3;+45");
    while (frame_q.size() < total) begin
      frame_q.push_back(sfp_pkg::CH_SEMI);
      repeat ($urandom_range(sfp_pkg::MAX_ARG_LEN_DEF + 4, sfp_pkg::MAX_ARG_LEN_DEF + 40)) begin
        frame_q.push_back(8'($urandom_range(64, 126)));
      end
    end
    while (frame_q.size() > total) void'(frame_q.pop_back());
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= MAX_SHOWN) begin
        $display("mismatch on record %0d, %s: expected %0h, got %0h",
                 recs_checked, name, want, got);
      end
    end
  endtask

  always @(negedge clk) begin
    if (rst || calm) begin
      tx_if.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      tx_if.ready <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left  <= $urandom_range(0, 7);
      tx_if.ready <= 1'b0;
    end else begin
      tx_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    sfp_pkg::rec_t got;
    sfp_pkg::rec_t want;
    if (!rst && tx_if.valid && tx_if.ready) begin
      got = {tx_if.kind, tx_if.arg_index, tx_if.arg_byte, tx_if.arg_length,
             tx_if.stream_number, tx_if.frame_number, tx_if.command_code,
             tx_if.arg_count, tx_if.status, tx_if.last_result};
      if (due_records.size() == 0) begin
        errors++;
        if (errors <= MAX_SHOWN) $display("record with none expected: %h", got);
      end else begin
        want = due_records.pop_front();
        check_field("kind", want.kind, got.kind);
        check_field("arg_index", want.arg_index, got.arg_index);
        check_field("arg_byte", want.arg_byte, got.arg_byte);
        check_field("arg_length", want.arg_length, got.arg_length);
        check_field("stream_number", want.stream_number, got.stream_number);
        check_field("frame_number", want.frame_number, got.frame_number);
        check_field("command_code", want.command_code, got.command_code);
        check_field("arg_count", want.arg_count, got.arg_count);
        check_field("status", want.status, got.status);
        check_field("last_result", want.last_result, got.last_result);
        if (want.kind == sfp_pkg::KIND_FINISH) fin_seen[want.status]++;
        recs_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout with %0d records still due", due_records.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    rx_if.valid     = 1'b0;
    rx_if.in_byte   = '0;
    rx_if.last_byte = 1'b0;
    tx_if.ready     = 1'b0;
    calm            = 1'b0;
    stall_left      = 0;
    reset_parser();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r]) begin
      frame_q.delete();
      push_text(directed_rows[r].text);
      frame_q.push_back(directed_rows[r].tail);
      send_frame(directed_rows[r].typed, directed_rows[r].status);
    end

    // hold the sender until every record so far has come out
    rx_if.valid <= 1'b0;
    @(negedge clk);
    while (due_records.size() != 0) @(negedge clk);

    build_frame(MANY_ARGS);
    send_frame(1'b0, sfp_pkg::ST_OK);
    build_long(LONG_BYTES);
    send_frame(1'b0, sfp_pkg::ST_OK);

    while (bytes_sent < ITEM_TARGET) begin
      if (bytes_sent >= CALM_FROM) calm = 1'b1;
      build_frame(-1);
      send_frame(1'b0, sfp_pkg::ST_OK);
    end

    rx_if.valid <= 1'b0;
    while (due_records.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    errors += due_records.size();

    $display("sent %0d payloads, %0d bytes (%0d parsed), checked %0d records",
             frames_sent, bytes_sent, live_bytes, recs_checked);
    $display("finish status: ok %0d, bad tag %0d, missing %0d, too many %0d, too long %0d",
             fin_seen[sfp_pkg::ST_OK], fin_seen[sfp_pkg::ST_BAD_TAG],
             fin_seen[sfp_pkg::ST_MISSING], fin_seen[sfp_pkg::ST_TOO_MANY],
             fin_seen[sfp_pkg::ST_TOO_LONG]);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
